/* rtl/wlf_pkg.sv */
package wlf_pkg;

  localparam int VAL_BITS      = 48;
  localparam int WEIGHT_BITS   = 47;
  localparam int QUO_BITS      = 49;
  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_BITS_DEF  = 20;
  localparam int MUL_DIG_W     = 16;
  localparam int MUL_DIG_N     = 8;

  // width of centred covariance / variance, signed
  function automatic int num_w(int frac);
    int mw;
    int sw;
    mw = 2 * VAL_BITS + WEIGHT_BITS;
    sw = VAL_BITS + 2 * frac;
    return ((mw > sw) ? mw : sw) + 2;
  endfunction

  // width of position offset, signed
  function automatic int pos_w(int frac, int pb);
    int s;
    s = pb + frac;
    return ((s > VAL_BITS) ? s : VAL_BITS) + 1;
  endfunction

endpackage

/* rtl/wlf_if.sv */
interface wlf_in_if import wlf_pkg::*; #(
  parameter int PosBits = POS_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [WEIGHT_BITS-1:0]     weight_total;
  logic signed [VAL_BITS-1:0] mean_x;
  logic signed [VAL_BITS-1:0] mean_y;
  logic signed [VAL_BITS-1:0] sum_xx;
  logic signed [VAL_BITS-1:0] sum_xy;
  logic [PosBits-1:0]         eval_position;

  modport source (output valid, weight_total, mean_x, mean_y, sum_xx, sum_xy, eval_position,
                  input ready);
  modport sink (input valid, weight_total, mean_x, mean_y, sum_xx, sum_xy, eval_position,
                output ready);
endinterface

interface wlf_out_if import wlf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [VAL_BITS-1:0] estimate;
  logic                       degenerate;

  modport source (output valid, estimate, degenerate, input ready);
  modport sink (input valid, estimate, degenerate, output ready);
endinterface

/* rtl/wlf_mul.sv */
module wlf_mul #(
  parameter int AW = 8,
  parameter int BW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [SW-1:0]    side_i,
  output logic [AW+BW-1:0] p_o,
  output logic [SW-1:0]    side_o
);
  localparam int NS = (BW + DW - 1) / DW;
  localparam int BP = NS * DW;
  localparam int PW = AW + BW;

  logic [AW-1:0]    a_q    [NS];
  logic [BP-1:0]    b_q    [NS];
  logic [PW-1:0]    acc_q  [NS];
  logic [SW-1:0]    side_q [NS];
  logic [AW+DW-1:0] pp     [NS];
  logic [BP-1:0]    b_ext;

  assign b_ext = BP'(b_i);

  // one digit of b per stage
  always_comb begin
    pp[0] = a_i * b_ext[DW-1:0];
    for (int k = 1; k < NS; k++) begin
      pp[k] = a_q[k-1] * b_q[k-1][k*DW +: DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]    <= a_i;
      b_q[0]    <= b_ext;
      acc_q[0]  <= PW'(pp[0]);
      side_q[0] <= side_i;
      for (int k = 1; k < NS; k++) begin
        a_q[k]    <= a_q[k-1];
        b_q[k]    <= b_q[k-1];
        side_q[k] <= side_q[k-1];
        acc_q[k]  <= acc_q[k-1] + (PW'(pp[k]) << (k * DW));
      end
    end
  end

  assign p_o    = acc_q[NS-1];
  assign side_o = side_q[NS-1];
endmodule

/* rtl/wlf_front.sv */
module wlf_front import wlf_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int POSITION_BITS = POS_BITS_DEF,
  localparam int NW = num_w(FRAC_BITS),
  localparam int PW = pos_w(FRAC_BITS, POSITION_BITS),
  localparam int QW = NW + PW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [WEIGHT_BITS-1:0]   weight_total_i,
  input  logic [VAL_BITS-1:0]      mean_x_i,
  input  logic [VAL_BITS-1:0]      mean_y_i,
  input  logic [VAL_BITS-1:0]      sum_xx_i,
  input  logic [VAL_BITS-1:0]      sum_xy_i,
  input  logic [POSITION_BITS-1:0] eval_position_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [QW-1:0]            prod_o,
  output logic [NW-1:0]            den_o,
  output logic                     neg_o,
  output logic                     deg_o,
  output logic [VAL_BITS-1:0]      y_o
);
  localparam int VW  = VAL_BITS;
  localparam int WB  = WEIGHT_BITS;
  localparam int XW  = 2 * VW;
  localparam int MW  = XW + WB;
  localparam int L1  = (VW + MUL_DIG_W - 1) / MUL_DIG_W;
  localparam int L2  = (WB + MUL_DIG_W - 1) / MUL_DIG_W;
  localparam int L3  = (PW + MUL_DIG_N - 1) / MUL_DIG_N;
  localparam int LT  = 3 + L1 + L2 + L3;
  localparam int SA  = WB + 2 * VW + 1;
  localparam int SB  = VW + PW;
  localparam int SC  = 2 * VW + 1;
  localparam int SE  = NW + 2 + VW;
  localparam int SH  = 2 * FRAC_BITS;

  logic          en;
  logic [LT-1:0] v_q;

  // input stage
  logic [VW-1:0] ax_q, ay_q, y0_q, sxx0_q, sxy0_q;
  logic [WB-1:0] w0_q;
  logic [PW-1:0] p0_q;
  logic          sgn0_q;
  logic [VW-1:0] ax_d, ay_d;
  logic [PW-1:0] p_d;

  // products
  logic [XW-1:0] m_xy, m_xx;
  logic [SA-1:0] side_a;
  logic [SB-1:0] side_b;
  logic [MW-1:0] m1, m2;
  logic [SC-1:0] side_c;
  logic [SB-1:0] side_d;
  logic [WB-1:0] w1;
  logic [VW-1:0] y1, sxy1, y2, sxy2, sxx1, sxx2;
  logic          sgn1, sgn2;
  logic [PW-1:0] p1, p2;

  // centred terms
  logic [NW-1:0] n_q, d_q, n_d, d_d, sh_xy, sh_xx, m1e, m2e;
  logic [PW-1:0] p3_q;
  logic [VW-1:0] y3_q;

  // magnitudes
  logic [NW-1:0] an_q, ad_q;
  logic [PW-1:0] ap_q;
  logic          neg_q, deg_q;
  logic [VW-1:0] y4_q;
  logic [SE-1:0] side_e;

  assign en      = !v_q[LT-1] || ready_i;
  assign ready_o = en;
  assign valid_o = v_q[LT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LT-2:0], valid_i};
    end
  end

  always_comb begin
    ax_d = mean_x_i[VW-1] ? (~mean_x_i + 1'b1) : mean_x_i;
    ay_d = mean_y_i[VW-1] ? (~mean_y_i + 1'b1) : mean_y_i;
    p_d  = PW'({eval_position_i, {FRAC_BITS{1'b0}}})
           - {{(PW-VW){mean_x_i[VW-1]}}, mean_x_i};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      sgn0_q <= mean_x_i[VW-1] ^ mean_y_i[VW-1];
      w0_q   <= weight_total_i;
      y0_q   <= mean_y_i;
      sxx0_q <= sum_xx_i;
      sxy0_q <= sum_xy_i;
      p0_q   <= p_d;
    end
  end

  wlf_mul #(.AW(VW), .BW(VW), .DW(MUL_DIG_W), .SW(SA)) u_mul_xy (
    .clk_i, .en_i(en), .a_i(ax_q), .b_i(ay_q),
    .side_i({w0_q, y0_q, sxy0_q, sgn0_q}), .p_o(m_xy), .side_o(side_a)
  );

  wlf_mul #(.AW(VW), .BW(VW), .DW(MUL_DIG_W), .SW(SB)) u_mul_xx (
    .clk_i, .en_i(en), .a_i(ax_q), .b_i(ax_q),
    .side_i({sxx0_q, p0_q}), .p_o(m_xx), .side_o(side_b)
  );

  assign {w1, y1, sxy1, sgn1} = side_a;
  assign {sxx1, p1}           = side_b;

  wlf_mul #(.AW(XW), .BW(WB), .DW(MUL_DIG_W), .SW(SC)) u_mul_xyw (
    .clk_i, .en_i(en), .a_i(m_xy), .b_i(w1),
    .side_i({y1, sxy1, sgn1}), .p_o(m1), .side_o(side_c)
  );

  wlf_mul #(.AW(XW), .BW(WB), .DW(MUL_DIG_W), .SW(SB)) u_mul_xxw (
    .clk_i, .en_i(en), .a_i(m_xx), .b_i(w1),
    .side_i({sxx1, p1}), .p_o(m2), .side_o(side_d)
  );

  assign {y2, sxy2, sgn2} = side_c;
  assign {sxx2, p2}       = side_d;

  always_comb begin
    sh_xy = {{(NW-VW-SH){sxy2[VW-1]}}, sxy2, {SH{1'b0}}};
    sh_xx = {{(NW-VW-SH){sxx2[VW-1]}}, sxx2, {SH{1'b0}}};
    m1e   = NW'(m1);
    m2e   = NW'(m2);
    n_d   = sgn2 ? (sh_xy + m1e) : (sh_xy - m1e);
    d_d   = sh_xx - m2e;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q  <= n_d;
      d_q  <= d_d;
      p3_q <= p2;
      y3_q <= y2;
      an_q  <= n_q[NW-1] ? (~n_q + 1'b1) : n_q;
      ad_q  <= d_q[NW-1] ? (~d_q + 1'b1) : d_q;
      ap_q  <= p3_q[PW-1] ? (~p3_q + 1'b1) : p3_q;
      neg_q <= n_q[NW-1] ^ d_q[NW-1] ^ p3_q[PW-1];
      deg_q <= (d_q == '0);
      y4_q  <= y3_q;
    end
  end

  wlf_mul #(.AW(NW), .BW(PW), .DW(MUL_DIG_N), .SW(SE)) u_mul_np (
    .clk_i, .en_i(en), .a_i(an_q), .b_i(ap_q),
    .side_i({ad_q, neg_q, deg_q, y4_q}), .p_o(prod_o), .side_o(side_e)
  );

  assign {den_o, neg_o, deg_o, y_o} = side_e;
endmodule

/* rtl/wlf_queue.sv */
module wlf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end
endmodule

/* rtl/wlf_back.sv */
module wlf_back import wlf_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int POSITION_BITS = POS_BITS_DEF,
  localparam int NW = num_w(FRAC_BITS),
  localparam int PW = pos_w(FRAC_BITS, POSITION_BITS),
  localparam int QW = NW + PW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [QW-1:0]       prod_i,
  input  logic [NW-1:0]       den_i,
  input  logic                neg_i,
  input  logic                deg_i,
  input  logic [VAL_BITS-1:0] y_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [VAL_BITS-1:0] est_o,
  output logic                deg_o
);
  localparam int VW = VAL_BITS;
  localparam int QB = QUO_BITS;
  localparam int LT = QB + 3;
  localparam int SW = QB + 2;

  logic          en;
  logic [LT-1:0] v_q;

  logic [QW-1:0] r_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic [NW-1:0] ad_q  [QB+1];
  logic [VW-1:0] y_q   [QB+1];
  logic          neg_q [QB+1];
  logic          deg_q [QB+1];
  logic          ovf_q [QB+1];
  logic [QW-1:0] t_c   [QB+1];
  logic          ge_c  [QB+1];

  logic [QB:0]   qv_q;
  logic          rovf_q, rneg_q, rdeg_q;
  logic [VW-1:0] ry_q;
  logic          rnd;

  logic [SW-1:0] s_d;
  logic [VW-1:0] est_d;
  logic [VW-1:0] est_q;
  logic          dg_q;

  assign en      = !v_q[LT-1] || ready_i;
  assign ready_o = en;
  assign valid_o = v_q[LT-1];
  assign est_o   = est_q;
  assign deg_o   = dg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LT-2:0], valid_i};
    end
  end

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    t_c[0]  = QW'(den_i) << QB;
    ge_c[0] = (prod_i >= t_c[0]);
    for (int j = 1; j <= QB; j++) begin
      t_c[j]  = QW'(ad_q[j-1]) << (QB - j);
      ge_c[j] = (r_q[j-1] >= t_c[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]   <= prod_i;
      q_q[0]   <= '0;
      ad_q[0]  <= den_i;
      y_q[0]   <= y_i;
      neg_q[0] <= neg_i;
      deg_q[0] <= deg_i;
      ovf_q[0] <= ge_c[0];
      for (int j = 1; j <= QB; j++) begin
        r_q[j]   <= ge_c[j] ? (r_q[j-1] - t_c[j]) : r_q[j-1];
        q_q[j]   <= q_q[j-1] | (QB'(ge_c[j]) << (QB - j));
        ad_q[j]  <= ad_q[j-1];
        y_q[j]   <= y_q[j-1];
        neg_q[j] <= neg_q[j-1];
        deg_q[j] <= deg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  // round half away from zero on the magnitude
  assign rnd = ({r_q[QB][NW-1:0], 1'b0} >= {1'b0, ad_q[QB]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      qv_q   <= (QB+1)'(q_q[QB]) + (QB+1)'(rnd);
      rovf_q <= ovf_q[QB];
      rneg_q <= neg_q[QB];
      rdeg_q <= deg_q[QB];
      ry_q   <= y_q[QB];
    end
  end

  always_comb begin
    s_d = rneg_q ? ({{(SW-VW){ry_q[VW-1]}}, ry_q} - SW'(qv_q))
                 : ({{(SW-VW){ry_q[VW-1]}}, ry_q} + SW'(qv_q));
    if (rdeg_q) begin
      est_d = '0;
    end else if (rovf_q) begin
      est_d = rneg_q ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else if (!s_d[SW-1] && (|s_d[SW-2:VW-1])) begin
      est_d = {1'b0, {(VW-1){1'b1}}};
    end else if (s_d[SW-1] && !(&s_d[SW-2:VW-1])) begin
      est_d = {1'b1, {(VW-1){1'b0}}};
    end else begin
      est_d = s_d[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      est_q <= est_d;
      dg_q  <= rdeg_q;
    end
  end
endmodule

/* rtl/weighted_linear_fit_eval.sv */
// channel  dir  handshake      payload
// in_i     in   valid/ready    weight_total, mean_x, mean_y, sum_xx, sum_xy, eval_position
// out_o    out  valid/ready    estimate, degenerate
//
// One item per clock sustained while the output is not stalled. The path runs through
// the front multiplier chain (PW = position offset width, 49 by default), the
// two-entry queue and the divider pipeline (one quotient bit per stage). Reset
// clears only valid bits and the queue pointers and count.
// Front and back stall independently; the queue absorbs the difference.
module weighted_linear_fit_eval import wlf_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wlf_in_if.sink     in_i,
  wlf_out_if.source  out_o
);
  localparam int NW = num_w(FRAC_BITS);
  localparam int PW = pos_w(FRAC_BITS, POSITION_BITS);
  localparam int QW = NW + PW;
  localparam int EW = QW + NW + 2 + VAL_BITS;

  logic                f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0]       f_prod, b_prod;
  logic [NW-1:0]       f_den, b_den;
  logic                f_neg, f_deg, b_neg, b_deg;
  logic [VAL_BITS-1:0] f_y, b_y;
  logic [VAL_BITS-1:0] est;

  wlf_front #(.FRAC_BITS(FRAC_BITS), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i, .rst_ni,
    .valid_i(in_i.valid), .ready_o(in_i.ready),
    .weight_total_i(in_i.weight_total),
    .mean_x_i(in_i.mean_x), .mean_y_i(in_i.mean_y),
    .sum_xx_i(in_i.sum_xx), .sum_xy_i(in_i.sum_xy),
    .eval_position_i(in_i.eval_position),
    .valid_o(f_valid), .ready_i(f_ready),
    .prod_o(f_prod), .den_o(f_den), .neg_o(f_neg), .deg_o(f_deg), .y_o(f_y)
  );

  wlf_queue #(.WIDTH(EW)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready),
    .push_data_i({f_prod, f_den, f_neg, f_deg, f_y}),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready),
    .pop_data_o({b_prod, b_den, b_neg, b_deg, b_y})
  );

  wlf_back #(.FRAC_BITS(FRAC_BITS), .POSITION_BITS(POSITION_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(b_valid), .ready_o(b_ready),
    .prod_i(b_prod), .den_i(b_den), .neg_i(b_neg), .deg_i(b_deg), .y_i(b_y),
    .valid_o(out_o.valid), .ready_i(out_o.ready),
    .est_o(est), .deg_o(out_o.degenerate)
  );

  assign out_o.estimate = est;
endmodule

/* bench/weighted_linear_fit_eval_test.sv */
`timescale 1ns / 100ps

module weighted_linear_fit_eval_test;
  import wlf_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int PB = POS_BITS_DEF;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0]     w;
    logic signed [VAL_BITS-1:0] x;
    logic signed [VAL_BITS-1:0] y;
    logic signed [VAL_BITS-1:0] sxx;
    logic signed [VAL_BITS-1:0] sxy;
    logic [PB-1:0]              pos;
  } fit_item_t;

  typedef struct packed {
    logic                       degenerate;
    logic signed [VAL_BITS-1:0] estimate;
  } fit_res_t;

  class fit_scoreboard;
    fit_res_t pending_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function fit_res_t line_value(fit_item_t it);
      wide_t    w, x, y, num, den, p, prod, an, ad, q, r, est;
      wide_t    cap;
      fit_res_t res;
      logic     neg;
      w = $signed({1'b0, it.w});
      x = it.x;
      y = it.y;
      num = (wide_t'(it.sxy) <<< (2 * FB)) - x * y * w;
      den = (wide_t'(it.sxx) <<< (2 * FB)) - x * x * w;
      res.degenerate = 1'b0;
      res.estimate = '0;
      if (den == 0) begin
        res.degenerate = 1'b1;
        return res;
      end
      cap = wide_t'(1) <<< 51;
      p = ($signed({1'b0, it.pos}) <<< FB) - x;
      prod = num * p;
      neg = prod[255] != den[255];
      an = prod[255] ? -prod : prod;
      ad = den[255] ? -den : den;
      q = an / ad;
      r = an % ad;
      if (q >= cap) q = cap;
      else begin
        if ((r <<< 1) >= ad) q = q + 1;
        if (q > cap) q = cap;
      end
      est = neg ? y - q : y + q;
      if (est > ((wide_t'(1) <<< 47) - 1)) est = (wide_t'(1) <<< 47) - 1;
      if (est < -(wide_t'(1) <<< 47)) est = -(wide_t'(1) <<< 47);
      res.estimate = est[VAL_BITS-1:0];
      return res;
    endfunction

    function void note_input(fit_item_t it);
      pending_q.push_back(line_value(it));
    endfunction

    function void check_result(fit_res_t got);
      fit_res_t exp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result est=%0d deg=%0b", $time, got.estimate,
                 got.degenerate);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.estimate !== exp.estimate) begin
        $display("%0t: estimate expected %0d actual %0d", $time, exp.estimate, got.estimate);
        errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, exp.degenerate,
                 got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic no_idle = 1'b0;

  wlf_in_if #(.PosBits(PB)) in_if ();
  wlf_out_if out_if ();

  fit_scoreboard sb = new();

  weighted_linear_fit_eval #(.FRAC_BITS(FB), .POSITION_BITS(PB)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.weight_total = '0;
    in_if.mean_x = '0;
    in_if.mean_y = '0;
    in_if.sum_xx = '0;
    in_if.sum_xy = '0;
    in_if.eval_position = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= 15);
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result({out_if.degenerate, out_if.estimate});
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_fit(fit_item_t it);
    if (!no_idle) begin
      while ($urandom_range(99) < 15) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.weight_total <= it.w;
    in_if.mean_x <= it.x;
    in_if.mean_y <= it.y;
    in_if.sum_xx <= it.sxx;
    in_if.sum_xy <= it.sxy;
    in_if.eval_position <= it.pos;
    do @(negedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    @(posedge clk_i);
  endtask

  // window statistics built from a real weight, mean and spread
  function automatic fit_item_t window_fit();
    fit_item_t it;
    wide_t     w, x, y, v, c;
    it.w = WEIGHT_BITS'($urandom_range(32'h00ff_ffff, 1));
    it.x = {$urandom_range(PB > 20 ? 32'hfffff : (32'd1 << PB) - 32'd1, 0),
            16'($urandom)};
    it.y = $signed(48'(rand64())) >>> $urandom_range(20, 0);
    it.pos = PB'($urandom);
    w = $signed({1'b0, it.w});
    x = it.x;
    y = it.y;
    v = $signed({1'b0, 40'(rand64())}) >>> $urandom_range(30, 0);
    c = $signed(48'(rand64())) >>> $urandom_range(40, 8);
    it.sxx = VAL_BITS'(((x * x * w) >>> (2 * FB)) + v);
    it.sxy = VAL_BITS'(((x * y * w) >>> (2 * FB)) + c);
    return it;
  endfunction

  function automatic fit_item_t noise_fit();
    fit_item_t it;
    it.w = WEIGHT_BITS'(rand64());
    it.x = VAL_BITS'(rand64());
    it.y = VAL_BITS'(rand64());
    it.sxx = VAL_BITS'(rand64());
    it.sxy = VAL_BITS'(rand64());
    it.pos = PB'($urandom);
    return it;
  endfunction

  // exact zero variance: mean and weight on whole units
  function automatic fit_item_t flat_fit();
    fit_item_t it;
    longint    a, wu;
    it = noise_fit();
    a = longint'($urandom_range(200, 0));
    if ($urandom_range(1)) a = -a;
    wu = longint'($urandom_range(1000, 0));
    it.x = VAL_BITS'(a <<< 16);
    it.w = WEIGHT_BITS'(wu <<< 16);
    it.sxx = VAL_BITS'((a * a * wu) <<< 16);
    return it;
  endfunction

  task automatic run_directed();
    fit_item_t it;
    logic signed [VAL_BITS-1:0] vmax, vmin;
    vmax = {1'b0, {(VAL_BITS-1){1'b1}}};
    vmin = {1'b1, {(VAL_BITS-1){1'b0}}};
    it = '0;
    send_fit(it);
    it.pos = '1; it.y = vmax;
    send_fit(it);
    it = '0; it.w = '1; it.x = vmax; it.y = vmax; it.sxx = vmax; it.sxy = vmax; it.pos = '1;
    send_fit(it);
    it.x = vmin; it.y = vmin; it.sxx = vmin; it.sxy = vmin; it.pos = '0;
    send_fit(it);
    it = '0; it.sxx = 48'sd1; it.sxy = vmax; it.pos = '1;
    send_fit(it);
    it.sxy = vmin;
    send_fit(it);
    it = '0; it.sxx = -48'sd65536; it.sxy = 48'sd65536; it.pos = 20'd3; it.y = 48'sd100;
    send_fit(it);
    it = '0; it.w = 47'd65536; it.x = 48'sd65536; it.sxx = 48'sd65536; it.sxy = 48'sd7;
    send_fit(it);
    it = '0; it.w = 47'd65536; it.x = 48'sd131072; it.sxx = 48'sd327680;
    it.sxy = 48'sd400000; it.y = 48'sd65536; it.pos = 20'd5;
    send_fit(it);
    it = '0; it.sxx = 48'sd3; it.sxy = 48'sd1; it.pos = 20'd0; it.x = 48'sd32768;
    send_fit(it);
    it.x = -48'sd32768; it.sxy = -48'sd1;
    send_fit(it);
    it = '0; it.sxx = 48'sd65536; it.sxy = 48'sd65536; it.y = vmax; it.pos = '1;
    send_fit(it);
    it.y = vmin; it.sxy = -48'sd65536;
    send_fit(it);
    for (int k = 0; k < 4; k++) send_fit(flat_fit());
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    for (int n = 0; n < 400; n++) begin
      if (n == 150) no_idle <= 1'b1;
      if (n == 250) no_idle <= 1'b0;
      pick = $urandom_range(99);
      if (pick < 65) send_fit(window_fit());
      else if (pick < 75) send_fit(flat_fit());
      else send_fit(noise_fit());
    end
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
rtl/wlf_pkg.sv
rtl/wlf_if.sv
rtl/wlf_mul.sv
rtl/wlf_front.sv
rtl/wlf_queue.sv
rtl/wlf_back.sv
rtl/weighted_linear_fit_eval.sv
bench/weighted_linear_fit_eval_test.sv
